@@ rtl/mvlf_pkg.sv @@
// ----------------------------------------------------------------------------
// mvlf_pkg
// Shared constants and types for the majority vote level filter.
// ----------------------------------------------------------------------------
package mvlf_pkg;

    localparam int WINDOW = 10;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int VW     = (CNT_W > 4) ? CNT_W : 4;
    localparam int FREQ_W = 24;
    localparam int THR_W  = 4;

    typedef logic [1:0]        t_level;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [FREQ_W-1:0] t_freq;

    localparam t_level LVL_UNKNOWN = 2'd0;
    localparam t_level LVL_LOW     = 2'd1;
    localparam t_level LVL_MED     = 2'd2;
    localparam t_level LVL_HIGH    = 2'd3;

    typedef enum logic [1:0] {
        REG_THRESHOLD,
        REG_LOW_FREQ,
        REG_MED_FREQ,
        REG_HIGH_FREQ
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0] vote_threshold;
        t_freq            freq_lo;
        t_freq            freq_mid;
        t_freq            freq_hi;
    } t_cfg;

    typedef struct packed {
        t_count low;
        t_count med;
        t_count high;
    } t_tally;

endpackage

@@ rtl/mvlf_regs.sv @@
// ----------------------------------------------------------------------------
// mvlf_regs
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
module mvlf_regs
    import mvlf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    t_reg_idx   idx;

    assign idx   = t_reg_idx'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vote_threshold <= THR_W'(7);
            r_cfg.freq_lo        <= FREQ_W'(800000);
            r_cfg.freq_mid       <= FREQ_W'(1600000);
            r_cfg.freq_hi        <= FREQ_W'(2400000);
        end else if (wr_en) begin
            case (idx)
                REG_THRESHOLD: r_cfg.vote_threshold <= pwdata[THR_W-1:0];
                REG_LOW_FREQ:  r_cfg.freq_lo        <= pwdata[FREQ_W-1:0];
                REG_MED_FREQ:  r_cfg.freq_mid       <= pwdata[FREQ_W-1:0];
                REG_HIGH_FREQ: r_cfg.freq_hi        <= pwdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, r_cfg.vote_threshold};
            REG_LOW_FREQ:  prdata = {{(32-FREQ_W){1'b0}}, r_cfg.freq_lo};
            REG_MED_FREQ:  prdata = {{(32-FREQ_W){1'b0}}, r_cfg.freq_mid};
            REG_HIGH_FREQ: prdata = {{(32-FREQ_W){1'b0}}, r_cfg.freq_hi};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/mvlf_tally.sv @@
// ----------------------------------------------------------------------------
// mvlf_tally
// Prediction ring memory with running vote tallies. Each request reads the
// oldest entry, then writes the new one and adjusts the tallies.
// ----------------------------------------------------------------------------
module mvlf_tally
    import mvlf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_level i_predicted_level,
    output logic   o_ready,
    input  logic   i_busy,
    output t_tally o_tally,
    output logic   o_full_done
);

    typedef enum logic { S_IDLE, S_TALLY } t_state;

    t_state              r_state;
    t_level              r_ring [WINDOW];
    t_level              r_old;
    t_level              r_new;
    logic [SLOT_W-1:0]   r_slot;
    t_count              r_fill;
    t_tally              r_tally;
    logic                r_full_done;

    logic                accept;
    logic                full;
    t_tally              n_tally;
    t_count              n_fill;

    assign o_ready     = (r_state == S_IDLE) && !i_busy;
    assign accept      = i_valid && o_ready;
    assign full        = (r_fill == CNT_W'(WINDOW));
    assign o_tally     = r_tally;
    assign o_full_done = r_full_done;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old <= r_ring[r_slot];
            r_new <= i_predicted_level;
        end
        if (r_state == S_TALLY) begin
            r_ring[r_slot] <= r_new;
        end
    end

    always_comb begin
        n_tally = r_tally;
        if (full) begin
            case (r_old)
                LVL_LOW:  n_tally.low  = n_tally.low  - CNT_W'(1);
                LVL_MED:  n_tally.med  = n_tally.med  - CNT_W'(1);
                LVL_HIGH: n_tally.high = n_tally.high - CNT_W'(1);
                default: ;
            endcase
        end
        case (r_new)
            LVL_LOW:  n_tally.low  = n_tally.low  + CNT_W'(1);
            LVL_MED:  n_tally.med  = n_tally.med  + CNT_W'(1);
            LVL_HIGH: n_tally.high = n_tally.high + CNT_W'(1);
            default: ;
        endcase
        n_fill = full ? r_fill : r_fill + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_tally     <= '0;
            r_full_done <= 1'b0;
        end else begin
            r_full_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_TALLY;
                    end
                end
                S_TALLY: begin
                    if (!i_busy) begin
                        r_tally     <= n_tally;
                        r_fill      <= n_fill;
                        r_full_done <= (n_fill == CNT_W'(WINDOW));
                        r_slot      <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                                      : r_slot + SLOT_W'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/mvlf_decide.sv @@
// ----------------------------------------------------------------------------
// mvlf_decide
// Picks the winning level from the tallies, updates the stable level and the
// current frequency, and holds a result in the output register.
// ----------------------------------------------------------------------------
module mvlf_decide
    import mvlf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_tally        i_tally,
    input  logic          i_full_done,
    output logic          o_busy,
    output logic          o_valid,
    input  logic          i_ready,
    output t_freq         o_target_freq,
    output t_level        o_new_level,
    output logic [3:0]    o_winning_votes
);

    logic            r_pend;
    t_level          r_stable;
    t_freq           r_cur;
    logic            r_valid;
    t_freq           r_target;
    t_level          r_level;
    logic [3:0]      r_votes;

    logic            take;
    t_level          winner;
    t_count          count;
    logic [VW-1:0]   count_x;
    logic            change;
    t_freq           target;
    logic            emit;

    assign take   = r_pend && (!r_valid || i_ready);
    assign o_busy = r_pend && !take;

    always_comb begin
        if (i_tally.low >= i_tally.med && i_tally.low >= i_tally.high) begin
            winner = LVL_LOW;
            count  = i_tally.low;
            target = i_cfg.freq_lo;
        end else if (i_tally.med >= i_tally.high) begin
            winner = LVL_MED;
            count  = i_tally.med;
            target = i_cfg.freq_mid;
        end else begin
            winner = LVL_HIGH;
            count  = i_tally.high;
            target = i_cfg.freq_hi;
        end
        count_x = VW'(count);
        change  = (count_x >= VW'(i_cfg.vote_threshold)) && (winner != r_stable);
        emit    = change && (target != r_cur);
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_target <= target;
            r_level  <= winner;
            r_votes  <= (count_x > VW'(15)) ? 4'd15 : count_x[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_stable <= LVL_UNKNOWN;
            r_cur    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_full_done) begin
                r_pend <= 1'b1;
            end else if (take) begin
                r_pend <= 1'b0;
            end
            if (take && change) begin
                r_stable <= winner;
            end
            if (take && emit) begin
                r_cur   <= target;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_target_freq   = r_target;
    assign o_new_level     = r_level;
    assign o_winning_votes = r_votes;

endmodule

@@ rtl/majority_vote_level_filter_core.sv @@
// ----------------------------------------------------------------------------
// majority_vote_level_filter_core
// Sliding-window majority vote over predicted performance levels, requesting
// a new frequency when the stable level changes and its frequency differs.
//
//   Channel   Direction  Handshake             Payload
//   input     in         i_valid / o_ready     i_predicted_level
//   result    out        o_valid / i_ready     o_target_freq, o_new_level,
//                                              o_winning_votes
//   config    in         psel/penable/pready   paddr, pwdata, prdata
//
// A request first reads the oldest ring entry from the memory, then writes the
// new entry and adjusts the vote tallies.
// Voting follows the full and then pending flag, alongside the next request.
// A decision waits while the output register holds a result not yet taken,
// and the next request then holds in its tally cycle until the decision goes.
// Reset clears the tallies and counters; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
module majority_vote_level_filter_core
    import mvlf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_predicted_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_target_freq,
    output logic [1:0]  o_new_level,
    output logic [3:0]  o_winning_votes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   cfg;
    t_tally tally;
    logic   full_done;
    logic   busy;

    assign pready = 1'b1;

    mvlf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    mvlf_tally u_tally (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_predicted_level (i_predicted_level),
        .o_ready           (o_ready),
        .i_busy            (busy),
        .o_tally           (tally),
        .o_full_done       (full_done)
    );

    mvlf_decide u_decide (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_tally         (tally),
        .i_full_done     (full_done),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_target_freq   (o_target_freq),
        .o_new_level     (o_new_level),
        .o_winning_votes (o_winning_votes)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the majority vote level filter core. Directed
// tests cover reset values, warm-up, a zero threshold, vote ties, an unchanged
// frequency and a threshold above the window. Random traffic then runs
// through many register settings. Every result is compared with an
// independent model of the vote window.
// ----------------------------------------------------------------------------
module tb_top
    import mvlf_pkg::*;
();

    localparam int ITEMS_TARGET   = 1150;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_LIMIT    = 5000;

    typedef struct {
        t_freq      freq;
        t_level     level;
        logic [3:0] votes;
    } t_freq_change;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        o_ready;
    logic [1:0]  i_predicted_level = 2'd0;
    logic        o_valid;
    logic        i_ready           = 1'b0;
    logic [23:0] o_target_freq;
    logic [1:0]  o_new_level;
    logic [3:0]  o_winning_votes;
    logic        psel              = 1'b0;
    logic        penable           = 1'b0;
    logic        pwrite            = 1'b0;
    logic [3:0]  paddr             = 4'd0;
    logic [31:0] pwdata            = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Model of the filter state and its registers.
    t_cfg         cfg_model;
    t_level       window_model [WINDOW];
    int           window_slot;
    int           window_fill;
    t_level       model_level;
    t_freq        current_freq;
    t_freq_change pending_changes [$];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int rx_mode       = 0;
    int rx_left       = 0;

    majority_vote_level_filter_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_predicted_level (i_predicted_level),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_target_freq     (o_target_freq),
        .o_new_level       (o_new_level),
        .o_winning_votes   (o_winning_votes),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver switches between free flow, light, random and long stalls.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 80);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                i_ready <= ($urandom_range(0, 1) != 0);
            end
            default: begin
                i_ready <= ((rx_left % 12) < 2);
            end
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_freq_change want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_changes.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result freq %0d level %0d votes %0d",
                         $time, o_target_freq, o_new_level, o_winning_votes);
            end else begin
                want = pending_changes.pop_front();
                if (o_target_freq !== want.freq) begin
                    errors++;
                    $display("%0t ns: target_freq expected %0d, got %0d",
                             $time, want.freq, o_target_freq);
                end
                if (o_new_level !== want.level) begin
                    errors++;
                    $display("%0t ns: new_level expected %0d, got %0d",
                             $time, want.level, o_new_level);
                end
                if (o_winning_votes !== want.votes) begin
                    errors++;
                    $display("%0t ns: winning_votes expected %0d, got %0d",
                             $time, want.votes, o_winning_votes);
                end
            end
        end
    end

    function automatic logic [31:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_THRESHOLD: return {28'd0, cfg_model.vote_threshold};
            REG_LOW_FREQ:  return {8'd0, cfg_model.freq_lo};
            REG_MED_FREQ:  return {8'd0, cfg_model.freq_mid};
            default:       return {8'd0, cfg_model.freq_hi};
        endcase
    endfunction

    task automatic predict_level(input t_level lvl);
        int           n_low;
        int           n_med;
        int           n_high;
        int           votes;
        t_level       winner;
        t_freq        target;
        t_freq_change change;
        window_model[window_slot] = lvl;
        window_slot = (window_slot + 1 == WINDOW) ? 0 : window_slot + 1;
        if (window_fill < WINDOW) begin
            window_fill++;
        end
        if (window_fill < WINDOW) begin
            return;
        end
        n_low  = 0;
        n_med  = 0;
        n_high = 0;
        for (int k = 0; k < WINDOW; k++) begin
            case (window_model[k])
                LVL_LOW:  n_low++;
                LVL_MED:  n_med++;
                LVL_HIGH: n_high++;
                default:  ;
            endcase
        end
        if (n_low >= n_med && n_low >= n_high) begin
            winner = LVL_LOW;
            votes  = n_low;
            target = cfg_model.freq_lo;
        end else if (n_med >= n_high) begin
            winner = LVL_MED;
            votes  = n_med;
            target = cfg_model.freq_mid;
        end else begin
            winner = LVL_HIGH;
            votes  = n_high;
            target = cfg_model.freq_hi;
        end
        if (votes < int'(cfg_model.vote_threshold) || winner == model_level) begin
            return;
        end
        model_level = winner;
        if (target == current_freq) begin
            return;
        end
        current_freq = target;
        change.freq  = target;
        change.level = winner;
        change.votes = (votes > 15) ? 4'd15 : 4'(votes);
        pending_changes.push_back(change);
    endtask

    // Sends one prediction request; the sender idles between bursts of requests.
    task automatic send_level(input t_level lvl);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(30, 120);
            end else begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 16);
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid           <= 1'b1;
        i_predicted_level <= lvl;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        predict_level(lvl);
    endtask

    task automatic wait_until_quiet();
        int guard;
        @(negedge i_clk);
        i_valid <= 1'b0;
        guard = 0;
        while (pending_changes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_reg(input t_reg_idx idx);
        logic [31:0] want;
        want = reg_value(idx);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            errors++;
            $display("%0t ns: register %s read expected %0d, got %0d",
                     $time, idx.name(), want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_THRESHOLD: cfg_model.vote_threshold = value[3:0];
            REG_LOW_FREQ:  cfg_model.freq_lo        = value[23:0];
            REG_MED_FREQ:  cfg_model.freq_mid       = value[23:0];
            default:       cfg_model.freq_hi        = value[23:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_reg(idx);
    endtask

    task automatic test_reset_values();
        read_reg(REG_THRESHOLD);
        read_reg(REG_LOW_FREQ);
        read_reg(REG_MED_FREQ);
        read_reg(REG_HIGH_FREQ);
    endtask

    // Nothing is decided until the window is full; with a zero threshold an
    // all-unknown window then elects low with no votes.
    task automatic test_warmup_zero_threshold();
        set_reg(REG_THRESHOLD, 32'd0);
        set_reg(REG_LOW_FREQ, 32'hFFFF_FFFF);
        settings_used++;
        repeat (WINDOW) send_level(LVL_UNKNOWN);
        wait_until_quiet();
    endtask

    task automatic test_vote_ties();
        set_reg(REG_THRESHOLD, 32'd1);
        set_reg(REG_MED_FREQ, 32'd0);
        settings_used++;
        send_level(LVL_MED);
        send_level(LVL_LOW);
        send_level(LVL_HIGH);
        send_level(LVL_HIGH);
        send_level(LVL_MED);
        send_level(LVL_MED);
        wait_until_quiet();
    endtask

    // High becomes stable but its frequency equals the current one.
    task automatic test_same_frequency();
        set_reg(REG_HIGH_FREQ, 32'd0);
        settings_used++;
        send_level(LVL_HIGH);
        send_level(LVL_HIGH);
        wait_until_quiet();
    endtask

    task automatic test_threshold_above_window();
        set_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        settings_used++;
        repeat (3) send_level(LVL_LOW);
        wait_until_quiet();
    endtask

    task automatic pick_random_settings();
        logic [31:0] freq;
        case ($urandom_range(0, 9))
            0:       set_reg(REG_THRESHOLD, 32'd0);
            1:       set_reg(REG_THRESHOLD, 32'd10);
            2:       set_reg(REG_THRESHOLD, $urandom_range(11, 15));
            default: set_reg(REG_THRESHOLD, ($urandom & 32'hFFFF_FFF0)
                                            | $urandom_range(3, 8));
        endcase
        for (int r = REG_LOW_FREQ; r <= REG_HIGH_FREQ; r++) begin
            case ($urandom_range(0, 5))
                0:       freq = 32'd0;
                1:       freq = 32'h00FF_FFFF;
                2:       freq = {8'd0, cfg_model.freq_lo};
                default: freq = $urandom;
            endcase
            set_reg(t_reg_idx'(r), freq);
        end
        settings_used++;
    endtask

    // Mostly runs dominated by one level so the stable level moves, with
    // stretches of noise in between.
    task automatic test_random_traffic();
        int     phase_len;
        int     pause_at;
        int     run_len;
        int     n;
        t_level dominant;
        while (items_sent < ITEMS_TARGET) begin
            pick_random_settings();
            phase_len = $urandom_range(120, 260);
            pause_at  = $urandom_range(20, phase_len - 20);
            n         = 0;
            while (n < phase_len && items_sent < ITEMS_TARGET) begin
                if ($urandom_range(0, 6) != 0) begin
                    dominant = t_level'($urandom_range(1, 3));
                    run_len  = $urandom_range(6, 16);
                    for (int k = 0; k < run_len; k++) begin
                        if ($urandom_range(0, 9) < 8) begin
                            send_level(dominant);
                        end else begin
                            send_level(t_level'($urandom_range(0, 3)));
                        end
                    end
                end else begin
                    run_len = $urandom_range(1, 10);
                    for (int k = 0; k < run_len; k++) begin
                        send_level(t_level'($urandom_range(0, 3)));
                    end
                end
                if (n < pause_at && n + run_len >= pause_at) begin
                    wait_until_quiet();
                end
                n += run_len;
            end
            wait_until_quiet();
        end
    endtask

    initial begin
        cfg_model.vote_threshold = 4'd7;
        cfg_model.freq_lo        = 24'd800000;
        cfg_model.freq_mid       = 24'd1600000;
        cfg_model.freq_hi        = 24'd2400000;
        foreach (window_model[k]) begin
            window_model[k] = LVL_UNKNOWN;
        end
        window_slot  = 0;
        window_fill  = 0;
        model_level  = LVL_UNKNOWN;
        current_freq = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_warmup_zero_threshold();
        test_vote_ties();
        test_same_frequency();
        test_threshold_above_window();
        test_random_traffic();
        wait_until_quiet();

        if (pending_changes.size() != 0) begin
            errors += pending_changes.size();
            $display("%0t ns: %0d expected results never arrived",
                     $time, pending_changes.size());
        end
        $display("Sent %0d predictions and checked %0d frequency requests",
                 items_sent, results_seen);
        $display("across %0d register settings, with random stalls on both sides.",
                 settings_used);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Run timed out after %0d predictions.", items_sent);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mvlf_pkg.sv
rtl/mvlf_regs.sv
rtl/mvlf_tally.sv
rtl/mvlf_decide.sv
rtl/majority_vote_level_filter_core.sv
tb/tb_top.sv
